/* hdl/tsc_pkg.sv */
package tsc_pkg;

  // Default counter width and the fixed width of each result field
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned OUT_WIDTH       = 16;
  localparam int unsigned OUT_FIELDS      = 7;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

  // C-locale isspace: space, tab, newline, vertical tab, form feed, return
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) || ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z));
  endfunction

endpackage

/* hdl/text_statistics_counter.sv */
// A request is captured in the input register and updates the counts when it is consumed;
//   for a last request the totals are loaded into the result register at that same update.
// Throughput: one byte per cycle while no last request is held back by a waiting result.
// The master side holds one result register; while a result waits the slave side keeps
//   taking bytes, and only a further last request stalls until the result is taken.
// Reset (rst_ni low, asynchronous) clears all counts, line count to one, both sides empty.
module text_statistics_counter
  import tsc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // char_byte
  input  logic                          s_axis_tuser_i,  // has_char
  input  logic                          s_axis_tlast_i,  // last
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // char_total, word_total, line_total, digit_total, letter_total,
  // longest_start, longest_length (16 bits each, from bit 0 up)
  output logic [OUT_FIELDS*OUT_WIDTH-1:0] m_axis_tdata_o
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam cnt_t CNT_MAX  = '1;
  localparam cnt_t CNT_ZERO = '0;
  localparam cnt_t CNT_ONE  = cnt_t'(1);

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input cnt_t v);
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] ext;
    ext = {{OUT_WIDTH{1'b0}}, v};
    return ext[OUT_WIDTH-1:0];
  endfunction

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_has_q;
  logic       in_last_q;

  // running state
  cnt_t byte_q, word_q, line_q, digit_q, letter_q;
  cnt_t wstart_q, wlen_q, bstart_q, blen_q;
  logic inside_q;
  cnt_t byte_d, word_d, line_d, digit_d, letter_d;
  cnt_t wstart_d, wlen_d, bstart_d, blen_d;
  logic inside_d;

  // result register
  logic                            out_valid_q;
  logic [OUT_FIELDS*OUT_WIDTH-1:0] out_data_q;
  logic [OUT_FIELDS*OUT_WIDTH-1:0] out_data_d;

  logic out_free;
  logic consume;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign consume         = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || consume;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    byte_d   = byte_q;
    word_d   = word_q;
    line_d   = line_q;
    digit_d  = digit_q;
    letter_d = letter_q;
    wstart_d = wstart_q;
    wlen_d   = wlen_q;
    bstart_d = bstart_q;
    blen_d   = blen_q;
    inside_d = inside_q;

    if (in_has_q) begin
      if (in_char_q == CHAR_NL) begin
        line_d = sat_inc(line_q);
      end
      if (is_digit(in_char_q)) begin
        digit_d = sat_inc(digit_q);
      end else if (is_letter(in_char_q)) begin
        letter_d = sat_inc(letter_q);
      end
      if (is_space(in_char_q)) begin
        if (inside_q) begin
          if (wlen_q > blen_q) begin
            blen_d   = wlen_q;
            bstart_d = wstart_q;
          end
          word_d   = sat_inc(word_q);
          inside_d = 1'b0;
        end
      end else if (!inside_q) begin
        inside_d = 1'b1;
        wstart_d = byte_q;
        wlen_d   = CNT_ONE;
      end else begin
        wlen_d = sat_inc(wlen_q);
      end
      byte_d = sat_inc(byte_q);
    end

    // closing a text: finish an open word, then the totals leave and state restarts
    if (in_last_q) begin
      if (inside_d) begin
        if (wlen_d > blen_d) begin
          blen_d   = wlen_d;
          bstart_d = wstart_d;
        end
        word_d = sat_inc(word_d);
      end
    end

    out_data_d = {to_out(blen_d), to_out(bstart_d), to_out(letter_d), to_out(digit_d),
                  to_out(line_d), to_out(word_d), to_out(byte_d)};

    if (in_last_q) begin
      byte_d   = CNT_ZERO;
      word_d   = CNT_ZERO;
      line_d   = CNT_ONE;
      digit_d  = CNT_ZERO;
      letter_d = CNT_ZERO;
      wstart_d = CNT_ZERO;
      wlen_d   = CNT_ZERO;
      bstart_d = CNT_ZERO;
      blen_d   = CNT_ZERO;
      inside_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_has_q  <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q   <= CNT_ZERO;
      word_q   <= CNT_ZERO;
      line_q   <= CNT_ONE;
      digit_q  <= CNT_ZERO;
      letter_q <= CNT_ZERO;
      wstart_q <= CNT_ZERO;
      wlen_q   <= CNT_ZERO;
      bstart_q <= CNT_ZERO;
      blen_q   <= CNT_ZERO;
      inside_q <= 1'b0;
    end else if (consume) begin
      byte_q   <= byte_d;
      word_q   <= word_d;
      line_q   <= line_d;
      digit_q  <= digit_d;
      letter_q <= letter_d;
      wstart_q <= wstart_d;
      wlen_q   <= wlen_d;
      bstart_q <= bstart_d;
      blen_q   <= blen_d;
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= consume && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

/* tb/text_totals_checker.sv */
`timescale 1ns / 100ps

module text_totals_checker
  import tsc_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [7:0]                      s_data_i,
  input  logic                            s_user_i,
  input  logic                            s_last_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [OUT_FIELDS*OUT_WIDTH-1:0] m_data_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o,
  output int unsigned                     texts_o,
  output int unsigned                     requests_o
);

  typedef logic [OUT_WIDTH-1:0] cnt_t;

  // first field sits in the lowest bits of tdata
  typedef struct packed {
    cnt_t longest_length;
    cnt_t longest_start;
    cnt_t letter_total;
    cnt_t digit_total;
    cnt_t line_total;
    cnt_t word_total;
    cnt_t char_total;
  } text_totals_t;

  localparam cnt_t CNT_MAX = '1;

  string field_name [OUT_FIELDS] = '{"char_total", "word_total", "line_total", "digit_total",
                                     "letter_total", "longest_start", "longest_length"};

  cnt_t n_bytes, n_words, n_lines, n_digits, n_letters;
  cnt_t cur_start, cur_len, best_start, best_len;
  logic in_word;
  text_totals_t totals_q [$];

  function automatic cnt_t bump(input cnt_t v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic clear_counts();
    n_bytes    = '0;
    n_words    = '0;
    n_lines    = cnt_t'(1);
    n_digits   = '0;
    n_letters  = '0;
    in_word    = 1'b0;
    cur_start  = '0;
    cur_len    = '0;
    best_start = '0;
    best_len   = '0;
  endtask

  task automatic end_word();
    if (in_word) begin
      // strictly longer only, so the first of equal words stays
      if (cur_len > best_len) begin
        best_len   = cur_len;
        best_start = cur_start;
      end
      n_words = bump(n_words);
      in_word = 1'b0;
    end
  endtask

  task automatic count_request(input logic [7:0] c, input logic has, input logic fin);
    text_totals_t t;
    if (has) begin
      if (c == CHAR_NL) n_lines = bump(n_lines);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        n_digits = bump(n_digits);
      end else if ((c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z)) begin
        n_letters = bump(n_letters);
      end
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
        end_word();
      end else if (!in_word) begin
        in_word   = 1'b1;
        cur_start = n_bytes;
        cur_len   = cnt_t'(1);
      end else begin
        cur_len = bump(cur_len);
      end
      n_bytes = bump(n_bytes);
    end
    if (fin) begin
      end_word();
      t.char_total     = n_bytes;
      t.word_total     = n_words;
      t.line_total     = n_lines;
      t.digit_total    = n_digits;
      t.letter_total   = n_letters;
      t.longest_start  = best_start;
      t.longest_length = best_len;
      totals_q = {totals_q, t};
      clear_counts();
    end
  endtask

  task automatic compare_totals(input text_totals_t exp_t, input text_totals_t got_t);
    logic [OUT_FIELDS*OUT_WIDTH-1:0] e;
    logic [OUT_FIELDS*OUT_WIDTH-1:0] g;
    cnt_t ef;
    cnt_t gf;
    int   i;
    e = exp_t;
    g = got_t;
    for (i = 0; i < OUT_FIELDS; i++) begin
      ef = e[i*OUT_WIDTH +: OUT_WIDTH];
      gf = g[i*OUT_WIDTH +: OUT_WIDTH];
      if (gf !== ef) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field_name[i], ef, gf);
        errors_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_counts();
      totals_q.delete();
      errors_o   = 0;
      pending_o  = 0;
      texts_o    = 0;
      requests_o = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (totals_q.size() == 0) begin
          $display("%0t ns: result with no text pending, expected none, actual %h",
                   $time, m_data_i);
          errors_o++;
        end else begin
          compare_totals(totals_q.pop_front(), m_data_i);
          texts_o++;
        end
      end
      if (s_valid_i && s_ready_i) begin
        count_request(s_data_i, s_user_i, s_last_i);
        requests_o++;
      end
      pending_o = totals_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tsc_pkg::*;

  localparam int unsigned RAND_ITEMS = 1100;

  logic                            clk;
  logic                            rst_n;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [OUT_FIELDS*OUT_WIDTH-1:0] m_axis_tdata;

  int unsigned errors, pending, texts, requests;
  int unsigned src_gap_max = 4;
  int unsigned sink_gap_max = 4;
  int unsigned items_sent = 0;

  text_statistics_counter i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  text_totals_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .s_last_i   (s_axis_tlast),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .texts_o    (texts),
    .requests_o (requests)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  // one request: random hold-off, then hold until accepted
  task automatic send_req(input logic [7:0] c, input logic has, input logic fin);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= has;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // bare_end closes with a marker carrying no byte; otherwise the last byte closes
  task automatic send_text(input logic [7:0] txt [$], input bit bare_end, input bit markers);
    int i;
    for (i = 0; i < txt.size(); i++) begin
      if (markers && $urandom_range(0, 15) == 0) begin
        send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_req(txt[i], 1'b1, !bare_end && (i == txt.size() - 1));
      items_sent++;
    end
    if (bare_end || txt.size() == 0) begin
      send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 6))
      0, 1:    return 8'($urandom_range(CHAR_LC_A, CHAR_LC_Z));
      2:       return 8'($urandom_range(CHAR_UC_A, CHAR_UC_Z));
      3:       return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      4:       return 8'($urandom_range(8'h80, 8'hFF));
      5:       return 8'($urandom_range(8'h21, 8'h7F));
      default: return 8'($urandom_range(8'h00, 8'h08));
    endcase
  endfunction

  function automatic logic [7:0] space_byte();
    if ($urandom_range(0, 2) == 0) return CHAR_SPACE;
    return CHAR_TAB + 8'($urandom_range(0, 4));
  endfunction

  task automatic random_text();
    logic [7:0] txt [$];
    int unsigned len, n_words, wl, gap_len, w, k;
    if ($urandom_range(0, 5) == 0) begin
      // noise
      len = $urandom_range(0, 24);
      repeat (len) txt = {txt, 8'($urandom_range(0, 255))};
    end else begin
      // short words so that equal lengths come up often
      n_words = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) txt = {txt, space_byte()};
      for (w = 0; w < n_words; w++) begin
        wl = $urandom_range(1, 6);
        for (k = 0; k < wl; k++) txt = {txt, word_byte()};
        if (w < n_words - 1 || $urandom_range(0, 1)) begin
          gap_len = $urandom_range(1, 2);
          repeat (gap_len) txt = {txt, space_byte()};
        end
      end
    end
    send_text(txt, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin
    logic [7:0] txt [$];
    int unsigned rand_base, i;

    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty text, then a one-byte text closed by its own byte
    txt = {};
    send_text(txt, 1'b1, 1'b0);
    txt = '{"x"};
    send_text(txt, 1'b0, 1'b0);
    // class boundaries, all whitespace kinds, high bytes, a stray marker in front
    send_req(8'hFF, 1'b0, 1'b0);
    txt = '{8'h00, "A", "z", CHAR_SPACE, "0", "9", CHAR_TAB, 8'hFF, 8'h80, CHAR_NL,
            8'h0B, "a", 8'h0C, "Z", CHAR_CR, 8'h7F};
    send_text(txt, 1'b1, 1'b0);
    // equal-length words: the first one wins
    txt = '{"a", "b", CHAR_SPACE, "e", "f", "g", CHAR_SPACE, "h", "i", "j"};
    send_text(txt, 1'b0, 1'b0);

    rand_base = items_sent;
    i = 0;
    while (items_sent - rand_base < RAND_ITEMS) begin
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      random_text();
      i++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Covered %0d texts (%0d random) over %0d requests, incl. empty and tied texts",
             texts, i, requests);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // result side: random stall before each result
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, sink_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

endmodule
